/* sv/rbc_pkg.sv */
`timescale 1ns / 1ps

package rbc_pkg;

   // Sequencer states of the backoff datapath.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_EFF,
      ST_RANGE,
      ST_JITTER,
      ST_ACC,
      ST_GROWTH,
      ST_UPDATE,
      ST_OUT
   } state_type;

   // Result status codes.
   localparam logic [1:0] STATUS_WAIT    = 2'd0;
   localparam logic [1:0] STATUS_SUCCESS = 2'd1;
   localparam logic [1:0] STATUS_GIVE_UP = 2'd2;

   // Configuration register indexes.
   localparam logic [2:0] REG_ATTEMPT_LIMIT = 3'd0;
   localparam logic [2:0] REG_INITIAL_DELAY = 3'd1;
   localparam logic [2:0] REG_MAX_DELAY     = 3'd2;
   localparam logic [2:0] REG_MULTIPLIER    = 3'd3;
   localparam logic [2:0] REG_JITTER        = 3'd4;
   localparam logic [2:0] REG_PRNG_SEED     = 3'd5;

   // Register values after reset.
   localparam logic [4:0]  RST_ATTEMPT_LIMIT = 5'd3;
   localparam logic [21:0] RST_INITIAL_DELAY = 22'd100;
   localparam logic [21:0] RST_MAX_DELAY     = 22'd30000;
   localparam logic [12:0] RST_MULTIPLIER    = 13'd512;
   localparam logic [16:0] RST_JITTER        = 17'd16384;
   localparam logic [31:0] SEED_DEFAULT      = 32'd2463534242;

   // Jitter fraction of 1.0 in Q1.16; larger settings are clipped to it.
   localparam logic [16:0] JITTER_ONE = 17'd65536;
   localparam logic [25:0] SUM_MAX    = 26'h3FF_FFFF;

   // One xorshift32 step; an all-zero state is replaced by the default seed.
   function automatic logic [31:0] xorshift32(input logic [31:0] s);
      logic [31:0] x;
      x = (s == 32'd0) ? SEED_DEFAULT : s;
      x = x ^ (x << 13);
      x = x ^ (x >> 17);
      x = x ^ (x << 5);
      return x;
   endfunction

endpackage

/* sv/retry_backoff_controller.sv */
// Retry backoff controller: each request transfer reports the outcome of one attempt of a
// run (error code, zero for success, and a retry-allowed flag) and produces exactly one
// response transfer saying whether to wait and retry, that the run succeeded, or that it
// gave up, together with the delay, the attempt number, the last error and the running
// total of delays. The base delay grows by a Q5.8 multiplier after every failure, capped by
// the maximum delay register, and is spread by xorshift32 jitter; every retry delay is at
// least 1 ms. All products go through one shared 31 x 18 bit multiplier under a small
// sequencer, and the block takes one request at a time: a success or give-up outcome
// passes through the decide and output states, a retry without jitter adds the effective
// base, growth and update states, and a retry with jitter also the range, jitter and
// accumulate states, the three serial uses of the multiplier making it the longest path.
// A new request is accepted in the cycle after the response register is loaded, even
// while that response is still waiting to be taken; a response stall only holds the block
// once the next result is ready to be loaded.
// Configuration registers are written through the csr port whenever the block is idle;
// writing the seed also reloads the generator.
`timescale 1ns / 1ps

module retry_backoff_controller
   import rbc_pkg::*;
#(
   parameter int ATTEMPT_CEILING = 16,
   parameter int DELAY_LIMIT_MS  = 3600000
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [15:0] error_code, [16] retry_allowed, [23:17] zero
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [21:0] backoff_ms, [26:22] attempt_number,
                                    // [42:27] error_seen, [68:43] backoff_total_ms,
                                    // [71:69] zero
   output logic [1:0]  rsp_tuser,   // [1:0] status
   // Configuration write channel.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   // The attempt limit is the smaller of the register and the parameter, never zero.
   localparam logic [4:0]  ATT_CLIP  = (ATTEMPT_CEILING > 31) ? 5'd31 : 5'(ATTEMPT_CEILING);
   localparam logic [21:0] LIMIT_MS  = 22'(DELAY_LIMIT_MS);

   // Configuration registers.
   logic [4:0]  max_att_ff,  max_att_in;
   logic [21:0] init_ff,     init_in;
   logic [21:0] max_dly_ff,  max_dly_in;
   logic [12:0] mult_ff,     mult_in;
   logic [16:0] jitter_ff,   jitter_in;

   // Run state.
   logic [4:0]  attempt_ff,  attempt_in;
   logic [29:0] base_ff,     base_in;
   logic [31:0] prng_ff,     prng_in;
   logic [25:0] sum_ff,      sum_in;
   logic [15:0] recent_ff,   recent_in;

   // Sequencer and working registers.
   state_type   state_ff, state_in;
   logic [15:0] err_ff,      err_in;
   logic        allowed_ff,  allowed_in;
   logic [1:0]  status_ff,   status_in;
   logic [4:0]  att_num_ff,  att_num_in;
   logic [29:0] eff_ff,      eff_in;
   logic [47:0] prod_ff,     prod_in;
   logic [21:0] delay_ff,    delay_in;

   // Response register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [71:0] rsp_data_ff,  rsp_data_in;
   logic [1:0]  rsp_user_ff,  rsp_user_in;

   // Shared multiplier: unsigned 30-bit operand times signed 18-bit operand.
   logic [29:0]        mul_a;
   logic signed [17:0] mul_b;
   logic signed [48:0] mul_full;

   // Combinational helpers.
   logic        req_fire;
   logic        out_free;
   logic [4:0]  limit;
   logic [21:0] max_dly_clip;
   logic [29:0] cap;
   logic [16:0] jit_clip;
   logic [17:0] s_val;
   logic [29:0] base_sel;
   logic signed [47:0] acc;
   logic [34:0] growth;
   logic [26:0] sum_wide;

   // Clamp a raw delay into 1 .. DELAY_LIMIT_MS.
   function automatic logic [21:0] clamp_delay(input logic [22:0] raw);
      logic [21:0] res;
      if (raw == 23'd0) begin
         res = 22'd1;
      end else if (raw > {1'b0, LIMIT_MS}) begin
         res = LIMIT_MS;
      end else begin
         res = raw[21:0];
      end
      return res;
   endfunction

   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   // Registers only change between items, so an item always sees one set of settings.
   assign csr_ready  = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   always_comb begin
      limit = (max_att_ff > ATT_CLIP) ? ATT_CLIP : max_att_ff;
      if (limit == 5'd0) begin
         limit = 5'd1;
      end
      max_dly_clip = (max_dly_ff > LIMIT_MS) ? LIMIT_MS : max_dly_ff;
      cap          = {max_dly_clip, 8'h00};
      jit_clip     = (jitter_ff > JITTER_ONE) ? JITTER_ONE : jitter_ff;
      // Jitter factor 2r - 1.0 in signed Q1.16, taken from the top half of the generator.
      s_val        = {1'b0, prng_ff[31:16], 1'b0} - 18'd65536;
      base_sel     = (attempt_ff <= 5'd1) ? {init_ff, 8'h00} : base_ff;
      acc          = $signed({2'b00, eff_ff, 16'h0000}) + $signed(prod_ff);
      growth       = prod_ff[42:8];
      sum_wide     = {1'b0, sum_ff} + {5'b00000, delay_ff};
   end

   // Operand selection for the shared multiplier.
   always_comb begin
      case (state_ff)
         ST_RANGE: begin
            mul_a = eff_ff;
            mul_b = $signed({1'b0, jit_clip});
         end
         ST_JITTER: begin
            mul_a = prod_ff[45:16];
            mul_b = $signed(s_val);
         end
         ST_GROWTH: begin
            mul_a = eff_ff;
            mul_b = $signed({5'b00000, mult_ff});
         end
         default: begin
            mul_a = eff_ff;
            mul_b = 18'sd0;
         end
      endcase
   end

   assign mul_full = $signed({1'b0, mul_a}) * mul_b;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (err_ff != 16'd0 && allowed_ff && attempt_ff < limit) begin
               state_in = ST_EFF;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_EFF: begin
            state_in = (jitter_ff != 17'd0) ? ST_RANGE : ST_GROWTH;
         end
         ST_RANGE:  state_in = ST_JITTER;
         ST_JITTER: state_in = ST_ACC;
         ST_ACC:    state_in = ST_GROWTH;
         ST_GROWTH: state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_OUT;
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and register updates driven by the sequencer.
   always_comb begin
      max_att_in   = max_att_ff;
      init_in      = init_ff;
      max_dly_in   = max_dly_ff;
      mult_in      = mult_ff;
      jitter_in    = jitter_ff;
      attempt_in   = attempt_ff;
      base_in      = base_ff;
      prng_in      = prng_ff;
      sum_in       = sum_ff;
      recent_in    = recent_ff;
      err_in       = err_ff;
      allowed_in   = allowed_ff;
      status_in    = status_ff;
      att_num_in   = att_num_ff;
      eff_in       = eff_ff;
      prod_in      = prod_ff;
      delay_in     = delay_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_ATTEMPT_LIMIT: max_att_in = csr_wdata[4:0];
            REG_INITIAL_DELAY: init_in    = csr_wdata[21:0];
            REG_MAX_DELAY:     max_dly_in = csr_wdata[21:0];
            REG_MULTIPLIER:    mult_in    = csr_wdata[12:0];
            REG_JITTER:        jitter_in  = csr_wdata[16:0];
            REG_PRNG_SEED:     prng_in    = csr_wdata;
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               err_in     = req_tdata[15:0];
               allowed_in = req_tdata[16];
            end
         end
         ST_DECIDE: begin
            att_num_in = attempt_ff;
            delay_in   = 22'd0;
            if (err_ff == 16'd0) begin
               status_in = STATUS_SUCCESS;
            end else begin
               recent_in = err_ff;
               if (!allowed_ff || attempt_ff >= limit) begin
                  status_in = STATUS_GIVE_UP;
               end else begin
                  status_in = STATUS_WAIT;
               end
            end
         end
         ST_EFF: begin
            eff_in = (base_sel < cap) ? base_sel : cap;
            if (jitter_ff != 17'd0) begin
               prng_in = xorshift32(prng_ff);
            end
         end
         ST_RANGE: begin
            prod_in = mul_full[47:0];
         end
         ST_JITTER: begin
            prod_in = mul_full[47:0];
         end
         ST_ACC: begin
            // The sum is never negative, since the jitter range never exceeds the base.
            delay_in = clamp_delay(acc[46:24]);
         end
         ST_GROWTH: begin
            prod_in = mul_full[47:0];
            if (jitter_ff == 17'd0) begin
               delay_in = clamp_delay({1'b0, eff_ff[29:8]});
            end
         end
         ST_UPDATE: begin
            base_in    = (growth < {5'b00000, cap}) ? growth[29:0] : cap;
            sum_in     = sum_wide[26] ? SUM_MAX : sum_wide[25:0];
            attempt_in = attempt_ff + 5'd1;
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = status_ff;
               rsp_data_in  = {3'b000, sum_ff, recent_ff, att_num_ff, delay_ff};
               if (status_ff != STATUS_WAIT) begin
                  // The run has ended: the next outcome opens a fresh run.
                  attempt_in = 5'd1;
                  base_in    = {init_ff, 8'h00};
                  sum_in     = 26'd0;
                  recent_in  = 16'd0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         max_att_ff   <= RST_ATTEMPT_LIMIT;
         init_ff      <= RST_INITIAL_DELAY;
         max_dly_ff   <= RST_MAX_DELAY;
         mult_ff      <= RST_MULTIPLIER;
         jitter_ff    <= RST_JITTER;
         attempt_ff   <= 5'd1;
         base_ff      <= {RST_INITIAL_DELAY, 8'h00};
         prng_ff      <= SEED_DEFAULT;
         sum_ff       <= 26'd0;
         recent_ff    <= 16'd0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         max_att_ff   <= max_att_in;
         init_ff      <= init_in;
         max_dly_ff   <= max_dly_in;
         mult_ff      <= mult_in;
         jitter_ff    <= jitter_in;
         attempt_ff   <= attempt_in;
         base_ff      <= base_in;
         prng_ff      <= prng_in;
         sum_ff       <= sum_in;
         recent_ff    <= recent_in;
      end
   end

   always_ff @(posedge clock) begin
      err_ff      <= err_in;
      allowed_ff  <= allowed_in;
      status_ff   <= status_in;
      att_num_ff  <= att_num_in;
      eff_ff      <= eff_in;
      prod_ff     <= prod_in;
      delay_ff    <= delay_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

`ifndef SYNTH
   // The attempt counter always stays within 1 .. the attempt ceiling clipped to 31.
   assert property (@(posedge clock) disable iff (reset)
      attempt_ff != 5'd0 && attempt_ff <= ATT_CLIP)
      else $error("attempt counter out of range");

   // A retry response always carries a nonzero delay, any other status a zero delay.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_user_ff == STATUS_WAIT) == (rsp_data_ff[21:0] != 22'd0)))
      else $error("delay does not match status");

   // Leaving the output state always loads the response register with the computed status.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && state_in == ST_IDLE) |=>
         (rsp_valid_ff && rsp_user_ff == $past(status_ff)))
      else $error("response not loaded on completion");
`endif

endmodule

/* tb/sv/retry_backoff_controller_tb.sv */
`timescale 1ns / 1ps

import rbc_pkg::*;

// One response as the block should present it.
typedef struct {
   logic [1:0]  status;
   logic [21:0] wait_ms;
   logic [4:0]  attempt;
   logic [15:0] seen_error;
   logic [25:0] total_ms;
} outcome_type;

// Tracks the backoff state alongside the block and checks its responses in order.
class backoff_scoreboard #(int ATTEMPT_CAP = 16, int LIMIT_MS = 3600000);
   logic [4:0]  cfg_attempts;
   logic [21:0] cfg_initial;
   logic [21:0] cfg_max_delay;
   logic [12:0] cfg_mult;
   logic [16:0] cfg_jitter;
   logic [31:0] cfg_seed;

   logic [4:0]  attempt_count;
   logic [29:0] base_q8;
   logic [31:0] gen_state;
   logic [25:0] delay_total;
   logic [15:0] run_error;

   outcome_type outcomes[$];
   int          fail_count;

   function new();
      cfg_attempts  = RST_ATTEMPT_LIMIT;
      cfg_initial   = RST_INITIAL_DELAY;
      cfg_max_delay = RST_MAX_DELAY;
      cfg_mult      = RST_MULTIPLIER;
      cfg_jitter    = RST_JITTER;
      cfg_seed      = SEED_DEFAULT;
      gen_state     = cfg_seed;
      fail_count    = 0;
      restart_run();
   endfunction

   function void restart_run();
      attempt_count = 5'd1;
      base_q8       = {cfg_initial, 8'd0};
      delay_total   = '0;
      run_error     = '0;
   endfunction

   function int pending();
      return outcomes.size();
   endfunction

   function void write_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
         REG_ATTEMPT_LIMIT: cfg_attempts  = val[4:0];
         REG_INITIAL_DELAY: cfg_initial   = val[21:0];
         REG_MAX_DELAY:     cfg_max_delay = val[21:0];
         REG_MULTIPLIER:    cfg_mult      = val[12:0];
         REG_JITTER:        cfg_jitter    = val[16:0];
         REG_PRNG_SEED: begin
            cfg_seed  = val;
            gen_state = val;
         end
         default: ;
      endcase
   endfunction

   // A stuck-at-zero generator restarts from the default seed before it steps.
   function logic [31:0] step_generator();
      logic [31:0] x;
      x = (gen_state == 32'd0) ? SEED_DEFAULT : gen_state;
      x = x ^ (x << 13);
      x = x ^ (x >> 17);
      x = x ^ (x << 5);
      gen_state = x;
      return x;
   endfunction

   // Delay for the current failure; also grows the stored base for the next one.
   function logic [21:0] next_delay();
      longint unsigned lim_ms, cap, base, eff, jit, nb, result;
      longint          r16, s, spread, acc;
      logic [31:0]     x;
      lim_ms = (cfg_max_delay > LIMIT_MS) ? LIMIT_MS : cfg_max_delay;
      cap    = lim_ms << 8;
      base   = (attempt_count <= 1) ? (64'(cfg_initial) << 8) : 64'(base_q8);
      eff    = (base < cap) ? base : cap;
      jit    = (cfg_jitter > JITTER_ONE) ? 64'(JITTER_ONE) : 64'(cfg_jitter);
      if (jit != 0) begin
         x      = step_generator();
         r16    = x[31:16];
         s      = 2 * r16 - 65536;
         spread = $signed((eff * jit) >> 16);
         acc    = $signed(eff << 16) + spread * s;
         if (acc < 0)
            acc = 0;
         result = $unsigned(acc) >> 24;
      end else begin
         result = eff >> 8;
      end
      if (result < 1)
         result = 1;
      if (result > LIMIT_MS)
         result = LIMIT_MS;
      nb      = (eff * cfg_mult) >> 8;
      base_q8 = 30'((nb < cap) ? nb : cap);
      return 22'(result);
   endfunction

   function void note_request(logic [15:0] err, logic allowed);
      outcome_type     o;
      int              lim;
      longint unsigned sum;
      lim = (cfg_attempts > ATTEMPT_CAP) ? ATTEMPT_CAP : cfg_attempts;
      if (lim < 1)
         lim = 1;
      o.attempt = attempt_count;
      o.wait_ms = '0;
      if (err == 16'd0) begin
         o.status = STATUS_SUCCESS;
      end else begin
         run_error = err;
         if (!allowed || attempt_count >= lim) begin
            o.status = STATUS_GIVE_UP;
         end else begin
            o.status  = STATUS_WAIT;
            o.wait_ms = next_delay();
            sum = 64'(delay_total) + 64'(o.wait_ms);
            if (sum > SUM_MAX)
               sum = SUM_MAX;
            delay_total   = 26'(sum);
            attempt_count = attempt_count + 5'd1;
         end
      end
      o.seen_error = run_error;
      o.total_ms   = delay_total;
      outcomes.push_back(o);
      if (o.status != STATUS_WAIT)
         restart_run();
   endfunction

   function void check_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   function void check_response(logic [1:0] status, logic [71:0] data);
      outcome_type o;
      if (outcomes.size() == 0) begin
         $error("response transfer with no outcome pending (status %0d)", status);
         fail_count++;
         return;
      end
      o = outcomes.pop_front();
      check_field("status", o.status, status);
      check_field("backoff_ms", o.wait_ms, data[21:0]);
      check_field("attempt_number", o.attempt, data[26:22]);
      check_field("error_seen", o.seen_error, data[42:27]);
      check_field("backoff_total_ms", o.total_ms, data[68:43]);
   endfunction
endclass

module retry_backoff_controller_tb;

   localparam int ATTEMPT_CEILING = 16;
   localparam int DELAY_LIMIT_MS  = 3600000;
   // The request count at which stimulus stops, directed part included.
   localparam int ITEM_TARGET    = 1350;
   // The block's longest path is a retry with jitter; the settle cycles past that path and more
   // cover the response register and the return to idle.
   localparam int SETTLE_CYCLES  = 16;
   // Worst correct gap between transfers is a full request gap, the block's
   // own processing and a full response stall, far below this limit.
   localparam int WATCHDOG_LIMIT = 2000;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;    // [15:0] error_code, [16] retry_allowed, [23:17] zero
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;         // [21:0] backoff_ms, [26:22] attempt_number,
                                   // [42:27] error_seen, [68:43] backoff_total_ms,
                                   // [71:69] zero
   logic [1:0]  rsp_tuser;         // [1:0] status
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   backoff_scoreboard #(ATTEMPT_CEILING, DELAY_LIMIT_MS) sb;

   // When set, neither side inserts gaps or stalls, so only the block itself paces the transfers.
   bit quiet = 1'b0;
   int sent = 0;
   int idle_cycles = 0;

   retry_backoff_controller #(
      .ATTEMPT_CEILING (ATTEMPT_CEILING),
      .DELAY_LIMIT_MS  (DELAY_LIMIT_MS)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Offers one attempt outcome after a random gap and returns once the
   // transfer has been taken. The valid is left high so that a following call
   // with no gap keeps the channel busy without a bubble.
   task automatic offer_attempt(input logic [15:0] err, input logic allowed);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 17);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, allowed, err};
      do @(posedge clock); while (!req_tready);
      sb.note_request(err, allowed);
      sent++;
   endtask

   // Waits until every outstanding response has been taken and the block has
   // had time to return to idle, so that registers may be written safely.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One register write; the valid drops for a cycle after each transfer.
   task automatic write_csr(input logic [2:0] idx, input logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, val);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [31:0] pick_delay(input bit allow_over);
      case ($urandom_range(0, 8))
         0:       return 32'd1;
         1:       return 32'd3600000;
         2:       return allow_over ? 32'd4194303 : 32'($urandom_range(1, 3600000));
         3, 4, 5: return 32'($urandom_range(1, 1000));
         6, 7:    return 32'($urandom_range(1, 100000));
         default: return 32'($urandom_range(1, 3600000));
      endcase
   endfunction

   // Writes a random subset of the registers, never none, favouring the
   // extremes and the clipped settings beyond the nominal ranges.
   task automatic configure_random();
      int written;
      written = 0;
      if ($urandom_range(0, 1)) begin
         case ($urandom_range(0, 9))
            0:       write_csr(REG_ATTEMPT_LIMIT, 32'd0);
            1:       write_csr(REG_ATTEMPT_LIMIT, 32'($urandom_range(17, 31)));
            2:       write_csr(REG_ATTEMPT_LIMIT, 32'd16);
            default: write_csr(REG_ATTEMPT_LIMIT, 32'($urandom_range(1, 16)));
         endcase
         written++;
      end
      if ($urandom_range(0, 1)) begin
         write_csr(REG_INITIAL_DELAY, pick_delay(1'b0));
         written++;
      end
      if ($urandom_range(0, 1)) begin
         write_csr(REG_MAX_DELAY, pick_delay(1'b1));
         written++;
      end
      if ($urandom_range(0, 1)) begin
         case ($urandom_range(0, 5))
            0:       write_csr(REG_MULTIPLIER, 32'd256);
            1:       write_csr(REG_MULTIPLIER, 32'd4096);
            default: write_csr(REG_MULTIPLIER, 32'($urandom_range(256, 4096)));
         endcase
         written++;
      end
      if ($urandom_range(0, 1) || written == 0) begin
         case ($urandom_range(0, 6))
            0:       write_csr(REG_JITTER, 32'd0);
            1:       write_csr(REG_JITTER, 32'd65536);
            2:       write_csr(REG_JITTER, 32'($urandom_range(65537, 131071)));
            default: write_csr(REG_JITTER, 32'($urandom_range(0, 65536)));
         endcase
      end
      if ($urandom_range(0, 1)) begin
         case ($urandom_range(0, 7))
            0:       write_csr(REG_PRNG_SEED, 32'd0);
            1:       write_csr(REG_PRNG_SEED, 32'hFFFF_FFFF);
            default: write_csr(REG_PRNG_SEED, $urandom);
         endcase
      end
   endtask

   // A well-formed run: a string of retryable failures, then either a success,
   // a refused retry, or nothing, so that the attempt limit or a later outcome ends it.
   task automatic offer_run();
      int fails;
      fails = $urandom_range(0, 16);
      repeat (fails) offer_attempt(16'($urandom_range(1, 65535)), 1'b1);
      case ($urandom_range(0, 2))
         0:       offer_attempt(16'd0, 1'($urandom_range(0, 1)));
         1:       offer_attempt(16'($urandom_range(1, 65535)), 1'b0);
         default: ;
      endcase
   endtask

   // Response side: stalls a random number of cycles before each transfer.
   initial begin
      int stall;
      while (reset) @(posedge clock);
      forever begin
         stall = quiet ? 0 : $urandom_range(0, 17);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   // Every response transfer is checked against the oldest outstanding outcome.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_response(rsp_tuser, rsp_tdata);
   end

   // Ends the run if no transfer of any kind happens for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin
      int target;
      sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: a plain success, two waits then the attempt limit, a
      // refused retry, and a success that reports the run's earlier error.
      offer_attempt(16'd0, 1'b0);
      offer_attempt(16'hFFFF, 1'b1);
      offer_attempt(16'd1, 1'b1);
      offer_attempt(16'h8000, 1'b1);
      offer_attempt(16'd5, 1'b0);
      offer_attempt(16'h1234, 1'b1);
      offer_attempt(16'd0, 1'b1);
      settle();

      // A zero attempt limit behaves as one, so the first failure gives up.
      write_csr(REG_ATTEMPT_LIMIT, 32'd0);
      write_csr(REG_JITTER, 32'd0);
      offer_attempt(16'd7, 1'b1);
      offer_attempt(16'd0, 1'b0);
      settle();

      // Upper extremes: limit above the cap, delays beyond the hard ceiling,
      // jitter above one, the largest nominal multiplier and a zero generator state.
      write_csr(REG_ATTEMPT_LIMIT, 32'd31);
      write_csr(REG_INITIAL_DELAY, 32'd4194303);
      write_csr(REG_MAX_DELAY, 32'd4194303);
      write_csr(REG_MULTIPLIER, 32'd4096);
      write_csr(REG_JITTER, 32'd131071);
      write_csr(REG_PRNG_SEED, 32'd0);
      repeat (16) offer_attempt(16'($urandom_range(1, 65535)), 1'b1);
      settle();

      // Lower extremes: a one millisecond base with full jitter, where the
      // spread can reach zero and the minimum delay must take over.
      write_csr(REG_ATTEMPT_LIMIT, 32'd4);
      write_csr(REG_INITIAL_DELAY, 32'd1);
      write_csr(REG_MAX_DELAY, 32'd1);
      write_csr(REG_MULTIPLIER, 32'd256);
      write_csr(REG_JITTER, 32'd65536);
      write_csr(REG_PRNG_SEED, 32'hFFFF_FFFF);
      repeat (4) offer_attempt(16'($urandom_range(1, 65535)), 1'b1);
      settle();

      // Random phases, each under its own settings, mostly complete runs
      // with some stray outcomes mixed in.
      while (sent < ITEM_TARGET) begin
         configure_random();
         quiet  = ($urandom_range(0, 3) == 0);
         target = sent + $urandom_range(40, 120);
         while (sent < target) begin
            if ($urandom_range(0, 9) < 8)
               offer_run();
            else
               offer_attempt(16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
         end
         settle();
      end

      if (sb.fail_count == 0 && sb.pending() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
